FILE: hw/rtl/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  localparam logic [2:0] EV_START    = 3'd0;
  localparam logic [2:0] EV_RESTART  = 3'd1;
  localparam logic [2:0] EV_SLAW_ACK = 3'd2;
  localparam logic [2:0] EV_DATA_ACK = 3'd3;
  localparam logic [2:0] EV_SLAR_ACK = 3'd4;
  localparam logic [2:0] EV_BYTE_RX  = 3'd5;

  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_START     = 3'd1;
  localparam logic [2:0] ACT_RSTART    = 3'd2;
  localparam logic [2:0] ACT_SEND      = 3'd3;
  localparam logic [2:0] ACT_RECV_NACK = 3'd4;
  localparam logic [2:0] ACT_STOP      = 3'd5;

  typedef enum logic [7:0] {
    PH_IDLE       = 8'b0000_0001,
    PH_ADDR_WRITE = 8'b0000_0010,
    PH_ADDR_REG   = 8'b0000_0100,
    PH_WRITING    = 8'b0000_1000,
    PH_RSTART     = 8'b0001_0000,
    PH_ADDR_READ  = 8'b0010_0000,
    PH_READING    = 8'b0100_0000,
    PH_STOP       = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [6:0] target_address;
    logic [7:0] target_register;
    logic [7:0] pending_data;
    logic       read_direction;
    logic       fault_flag;
  } ctx_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic       read_valid;
    logic       fault;
    logic       busy_res;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/i2c_master_register_access_fsm.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_stall   | operation, dev_addr,
//         |           |                       | reg_addr, write_data,
//         |           |                       | bus_event, received_byte
// out     | output    | out_valid / out_stall | bus_action, tx_byte, read_data,
//         |           |                       | read_valid, fault, busy_res
//
// One result per accepted input, one input per cycle while in_stall is low.
// The sequencer state updates at the accepting edge; its result is registered
// into the result register, or into the skid when the output is stalled.
// A two-entry output buffer (result register plus skid) lets input keep
// flowing under output stall until the skid fills; in_stall rises only when both are full.
// Synchronous reset returns the sequencer to idle and empties the buffer.
`default_nettype none

module i2c_master_register_access_fsm (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [6:0] dev_addr,
  input  logic [7:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic [2:0] bus_event,
  input  logic [7:0] received_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] bus_action,
  output logic [7:0] tx_byte,
  output logic [7:0] read_data,
  output logic       read_valid,
  output logic       fault,
  output logic       busy_res
);
  import i2cm_pkg::*;

  ctx_t    ctx;
  ctx_t    ctx_next;
  result_t res_next;
  result_t res;
  result_t skid;
  logic    skid_valid;
  logic    accept;
  logic    take;

  i2cm_step u_step (
    .cur           (ctx),
    .operation     (operation),
    .dev_addr      (dev_addr),
    .reg_addr      (reg_addr),
    .write_data    (write_data),
    .bus_event     (bus_event),
    .received_byte (received_byte),
    .nxt           (ctx_next),
    .res           (res_next)
  );

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign take     = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.phase           <= PH_IDLE;
      ctx.target_address  <= '0;
      ctx.target_register <= '0;
      ctx.pending_data    <= '0;
      ctx.read_direction  <= 1'b0;
      ctx.fault_flag      <= 1'b0;
    end else if (accept) begin
      ctx <= ctx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        res        <= skid;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || take) begin
        res       <= res_next;
        out_valid <= 1'b1;
      end else begin
        skid       <= res_next;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  assign bus_action = res.bus_action;
  assign tx_byte    = res.tx_byte;
  assign read_data  = res.read_data;
  assign read_valid = res.read_valid;
  assign fault      = res.fault;
  assign busy_res   = res.busy_res;

endmodule

`default_nettype wire

FILE: hw/rtl/i2cm_step.sv
`default_nettype none

module i2cm_step (
  input  i2cm_pkg::ctx_t    cur,
  input  logic [1:0]        operation,
  input  logic [6:0]        dev_addr,
  input  logic [7:0]        reg_addr,
  input  logic [7:0]        write_data,
  input  logic [2:0]        bus_event,
  input  logic [7:0]        received_byte,
  output i2cm_pkg::ctx_t    nxt,
  output i2cm_pkg::result_t res
);
  import i2cm_pkg::*;

  logic match;

  always_comb begin
    nxt   = cur;
    res   = '0;
    match = 1'b0;
    case (operation)
      OP_READ, OP_WRITE: begin
        // commands are dropped while a transaction is running
        if (cur.phase == PH_IDLE) begin
          nxt.target_address  = dev_addr;
          nxt.target_register = reg_addr;
          nxt.pending_data    = write_data;
          nxt.read_direction  = (operation == OP_READ);
          nxt.phase           = PH_ADDR_WRITE;
          res.bus_action      = ACT_START;
        end
      end
      OP_EVENT: begin
        case (cur.phase)
          PH_ADDR_WRITE: begin
            if (bus_event == EV_START) begin
              match          = 1'b1;
              res.bus_action = ACT_SEND;
              res.tx_byte    = {cur.target_address, 1'b0};
              nxt.phase      = PH_ADDR_REG;
            end
          end
          PH_ADDR_REG: begin
            if (bus_event == EV_SLAW_ACK) begin
              match          = 1'b1;
              res.bus_action = ACT_SEND;
              res.tx_byte    = cur.target_register;
              nxt.phase      = cur.read_direction ? PH_RSTART : PH_WRITING;
            end
          end
          PH_WRITING: begin
            if (bus_event == EV_DATA_ACK) begin
              match          = 1'b1;
              res.bus_action = ACT_SEND;
              res.tx_byte    = cur.pending_data;
              nxt.phase      = PH_STOP;
            end
          end
          PH_RSTART: begin
            if (bus_event == EV_DATA_ACK) begin
              match          = 1'b1;
              res.bus_action = ACT_RSTART;
              nxt.phase      = PH_ADDR_READ;
            end
          end
          PH_ADDR_READ: begin
            if (bus_event == EV_RESTART) begin
              match          = 1'b1;
              res.bus_action = ACT_SEND;
              res.tx_byte    = {cur.target_address, 1'b1};
              nxt.phase      = PH_READING;
            end
          end
          PH_READING: begin
            if (bus_event == EV_SLAR_ACK) begin
              match          = 1'b1;
              res.bus_action = ACT_RECV_NACK;
            end else if (bus_event == EV_BYTE_RX) begin
              match          = 1'b1;
              res.read_data  = received_byte;
              res.read_valid = 1'b1;
              res.bus_action = ACT_STOP;
              nxt.phase      = PH_IDLE;
            end
          end
          PH_STOP: begin
            // any event closes the bus, fault flag kept
            res.bus_action = ACT_STOP;
            nxt.phase      = PH_IDLE;
          end
          default: begin
            nxt.fault_flag = 1'b0;
          end
        endcase
        if (match) begin
          nxt.fault_flag = 1'b0;
        end else if (res.bus_action == ACT_NONE && nxt.phase != PH_IDLE) begin
          nxt.fault_flag = 1'b1;
          nxt.phase      = PH_STOP;
        end
      end
      default: begin
      end
    endcase
    res.fault    = nxt.fault_flag;
    res.busy_res = (nxt.phase != PH_IDLE);
  end

endmodule

`default_nettype wire

FILE: hw/rtl/i2cm_checker.sv
`default_nettype none

module i2cm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] bus_action,
  input logic [7:0] read_data,
  input logic       read_valid,
  input logic       fault,
  input logic       busy_res
);
  import i2cm_pkg::*;

  // a completed read always closes the bus and clears the fault
  a_read_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid |-> bus_action == ACT_STOP && !fault && !busy_res)
    else $error("read result without clean stop");

  // read data is only shown with its valid mark
  a_read_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_valid |-> read_data == 8'd0)
    else $error("read_data set without read_valid");

  // start, repeated start, send and receive all leave a transaction open
  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && (bus_action == ACT_START || bus_action == ACT_RSTART ||
                  bus_action == ACT_SEND || bus_action == ACT_RECV_NACK)
    |-> busy_res)
    else $error("bus action issued while idle");

  // a stop always returns the sequencer to idle
  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && bus_action == ACT_STOP |-> !busy_res)
    else $error("stop issued with transaction still open");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bus_action) && $stable(read_data))
    else $error("stalled result changed");

endmodule

bind i2c_master_register_access_fsm i2cm_checker u_i2cm_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .bus_action (bus_action),
  .read_data  (read_data),
  .read_valid (read_valid),
  .fault      (fault),
  .busy_res   (busy_res)
);

`default_nettype wire
